/* hdl/rtsp_pkg.sv */
// Package for the RTSP Transport header parser: phase codes, keyword masks,
// result kinds, register indices, result record and character helpers. No dependencies.
package rtsp_pkg;

  typedef enum logic [4:0] {
    PH_PROTO, PH_SLASH, PH_TAIL, PH_SEMI, PH_PSTART, PH_KEYWORD, PH_SKIP, PH_KWSP,
    PH_NUM_PRE, PH_NUM, PH_NUM_POST, PH_RANGE_PRE, PH_RANGE_NUM, PH_RANGE_POST,
    PH_CHAN2, PH_ADDR_PRE, PH_ADDR, PH_FAIL
  } phase_e;

  localparam int unsigned NumKw = 9;

  localparam logic [NumKw-1:0] K_UNI    = 9'h001;
  localparam logic [NumKw-1:0] K_MULTI  = 9'h002;
  localparam logic [NumKw-1:0] K_CLIENT = 9'h004;
  localparam logic [NumKw-1:0] K_SERVER = 9'h008;
  localparam logic [NumKw-1:0] K_PORT   = 9'h010;
  localparam logic [NumKw-1:0] K_DEST   = 9'h020;
  localparam logic [NumKw-1:0] K_SRC    = 9'h040;
  localparam logic [NumKw-1:0] K_SSRC   = 9'h080;
  localparam logic [NumKw-1:0] K_INTER  = 9'h100;
  localparam logic [NumKw-1:0] K_ALL    = 9'h1FF;

  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_DEST    = 2'd1;
  localparam logic [1:0] KIND_SRC     = 2'd2;

  localparam logic [1:0] REG_PROTO_TEXT = 2'd0;
  localparam logic [1:0] REG_PROTO_LEN  = 2'd1;
  localparam logic [1:0] REG_USE_TCP    = 2'd2;
  localparam logic [1:0] REG_CHANNEL    = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] idx;
    logic [7:0] chr;
    logic       ok;
    logic       uni;
    logic       multi;
    logic [31:0] client;
    logic [31:0] server;
    logic       ssrc_ok;
    logic [31:0] ssrc;
  } result_t;

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Keyword character at a position, 0 beyond its end.
  function automatic logic [7:0] kw_char(input int unsigned k, input logic [3:0] p);
    logic [87:0] s;
    case (k)
      0: s = {"unicast", 32'h0};
      1: s = {"multicast", 16'h0};
      2: s = {"client", "_port"};
      3: s = {"server", "_port"};
      4: s = {"port", 56'h0};
      5: s = "destination";
      6: s = {"source", 40'h0};
      7: s = {"ssrc", 56'h0};
      default: s = "interleaved";
    endcase
    if (p > 4'd10) return 8'h00;
    return s[8'd87 - 8'(p) * 8'd8 -: 8];
  endfunction

  function automatic logic [3:0] kw_len(input int unsigned k);
    case (k)
      0: return 4'd7;
      1: return 4'd9;
      4: return 4'd4;
      6: return 4'd6;
      7: return 4'd4;
      default: return 4'd11;
    endcase
  endfunction

endpackage

/* hdl/rtsp_step.sv */
// Next-state logic for one header byte of the RTSP Transport parser.
// Depends on rtsp_pkg.
module rtsp_step #(
  parameter int unsigned AddressBytes = 64
) (
  input  logic [7:0]            c_i,
  input  logic [63:0]           protocol_text_i,
  input  logic [3:0]            protocol_length_i,
  input  logic                  use_tcp_i,
  input  logic [7:0]            interleave_channel_i,
  input  rtsp_pkg::phase_e      phase_i,
  input  logic [8:0]            kw_i,
  input  logic [3:0]            pos_i,
  input  logic [31:0]           acc_i,
  input  logic [31:0]           first_i,
  input  logic [$clog2(AddressBytes)-1:0] cnt_i,
  input  logic                  failed_i,
  input  logic [2:0]            flags_i,
  input  logic [31:0]           client_i,
  input  logic [31:0]           server_i,
  input  logic [31:0]           ssrc_i,
  output rtsp_pkg::phase_e      phase_o,
  output logic [8:0]            kw_o,
  output logic [3:0]            pos_o,
  output logic [31:0]           acc_o,
  output logic [31:0]           first_o,
  output logic [$clog2(AddressBytes)-1:0] cnt_o,
  output logic                  failed_o,
  output logic [2:0]            flags_o,
  output logic [31:0]           client_o,
  output logic [31:0]           server_o,
  output logic [31:0]           ssrc_o,
  output logic                  emit_o,
  output rtsp_pkg::result_t     res_o
);
  import rtsp_pkg::*;

  localparam int unsigned CntW = $clog2(AddressBytes);
  localparam logic [CntW-1:0] CntMax = CntW'(AddressBytes - 1);

  logic       hex;
  logic       is_dig, is_hex;
  logic [3:0] dval;
  logic [31:0] acc10, acc16;
  logic [3:0] plen;
  logic [7:0] pchar, tchar;
  logic [8:0] keep, hit;
  logic [7:0] lc;
  logic       sp;

  always_comb begin
    lc = lower(c_i);
    sp = is_space(c_i);
    hex = (kw_i & K_SSRC) != '0;
    is_dig = c_i >= 8'h30 && c_i <= 8'h39;
    is_hex = lc >= 8'h61 && lc <= 8'h66;
    dval = is_dig ? 4'(c_i - 8'h30) : 4'(lc - 8'h57);
    acc10 = (acc_i << 3) + (acc_i << 1) + 32'(dval);
    acc16 = (acc_i << 4) + 32'(dval);
    plen = protocol_length_i > 4'd8 ? 4'd8 : protocol_length_i;
    pchar = protocol_text_i[{pos_i[2:0], 3'b000} +: 8];
    case (pos_i[1:0])
      2'd0: tchar = use_tcp_i ? 8'h74 : 8'h75;
      2'd1: tchar = use_tcp_i ? 8'h63 : 8'h64;
      default: tchar = use_tcp_i ? 8'h70 : 8'h70;
    endcase
    keep = '0;
    hit = '0;
    for (int unsigned i = 0; i < NumKw; i++) begin
      if (kw_i[i] && pos_i < kw_len(i) && lc == kw_char(i, pos_i)) begin
        keep[i] = 1'b1;
        if (pos_i + 4'd1 == kw_len(i)) hit = 9'(1) << i;
      end
    end
  end

  // Byte evaluation, flattened into direct cases per phase.
  always_comb begin
    logic fin, rej, fok, okfirst, rng_ok;
    logic [8:0] kwn, kp, kh;
    phase_o = phase_i; kw_o = kw_i; pos_o = pos_i; acc_o = acc_i; first_o = first_i;
    cnt_o = cnt_i; failed_o = failed_i; flags_o = flags_i;
    client_o = client_i; server_o = server_i; ssrc_o = ssrc_i;
    emit_o = 1'b0; res_o = '0;
    fin = 1'b0; rej = 1'b0; fok = 1'b1; okfirst = 1'b1;
    kwn = kw_i; rng_ok = 1'b0;
    kp = keep; kh = hit;
    case (phase_i)
      PH_PROTO, PH_SLASH: begin
        if (phase_i == PH_PROTO && pos_i < plen) begin
          if (c_i == 8'h00 || lc != lower(pchar)) rej = 1'b1;
          else pos_o = pos_i + 4'd1;
        end else if (c_i == 8'h2F) begin
          phase_o = PH_TAIL; pos_o = '0;
        end else if (c_i == 8'h3B) phase_o = PH_PSTART;
        else rej = 1'b1;
      end
      PH_TAIL: begin
        if (pos_i > 4'd2 || lc != tchar) rej = 1'b1;
        else begin
          pos_o = pos_i + 4'd1;
          if (pos_i == 4'd2) phase_o = PH_SEMI;
        end
      end
      PH_SEMI: if (c_i == 8'h3B) phase_o = PH_PSTART; else rej = 1'b1;
      PH_PSTART, PH_KEYWORD: begin
        if (c_i == 8'h00) fin = 1'b1;
        else if (phase_i == PH_PSTART && sp) phase_o = PH_PSTART;
        else begin
          if (phase_i == PH_PSTART) begin
            kwn = K_ALL;
            kp = '0; kh = '0;
            for (int unsigned i = 0; i < NumKw; i++) begin
              if (lc == kw_char(i, 4'd0)) kp[i] = 1'b1;
            end
            pos_o = '0;
          end
          if (kp == '0) begin
            phase_o = (c_i == 8'h3B) ? PH_PSTART : PH_SKIP;
            kw_o = kwn;
          end else if (kh != '0) begin
            kw_o = kh; phase_o = PH_KWSP;
          end else begin
            kw_o = kp; phase_o = PH_KEYWORD;
            pos_o = (phase_i == PH_PSTART) ? 4'd1 : pos_i + 4'd1;
          end
        end
      end
      PH_SKIP: if (c_i == 8'h00) fin = 1'b1; else if (c_i == 8'h3B) phase_o = PH_PSTART;
      PH_KWSP: begin
        if (!sp) begin
          if ((kw_i & (K_UNI | K_MULTI)) != '0) begin
            flags_o = flags_i | (((kw_i & K_UNI) != '0) ? 3'd1 : 3'd2);
            if (c_i == 8'h00) fin = 1'b1;
            else if (c_i == 8'h3B) phase_o = PH_PSTART;
            else rej = 1'b1;
          end else if (c_i != 8'h3D) rej = 1'b1;
          else begin
            acc_o = '0;
            phase_o = ((kw_i & (K_DEST | K_SRC)) != '0) ? PH_ADDR_PRE : PH_NUM_PRE;
          end
        end
      end
      PH_NUM_PRE, PH_NUM, PH_NUM_POST: begin
        if (phase_i != PH_NUM_POST && (is_dig || (hex && is_hex))) begin
          acc_o = hex ? acc16 : acc10; phase_o = PH_NUM;
        end else if (phase_i == PH_NUM_PRE && sp) phase_o = PH_NUM_PRE;
        else if (phase_i == PH_NUM_POST && sp) phase_o = PH_NUM_POST;
        else begin
          if (phase_i != PH_NUM_POST) begin
            if ((kw_i & K_CLIENT) != '0) client_o = acc_i;
            if ((kw_i & (K_SERVER | K_PORT)) != '0) server_o = acc_i;
            if ((kw_i & K_INTER) != '0) okfirst = acc_i == {24'h0, interleave_channel_i};
          end
          if (!okfirst) rej = 1'b1;
          else if (phase_i != PH_NUM_POST && sp) phase_o = PH_NUM_POST;
          else if ((kw_i & K_SSRC) != '0) begin
            if (c_i != 8'h00 && c_i != 8'h3B) rej = 1'b1;
            else begin
              flags_o = flags_i | 3'd4; ssrc_o = acc_i;
              if (c_i == 8'h00) fin = 1'b1; else phase_o = PH_PSTART;
            end
          end else if (c_i == 8'h2D) begin
            first_o = acc_i; acc_o = '0;
            phase_o = ((kw_i & K_INTER) != '0) ? PH_CHAN2 : PH_RANGE_PRE;
          end else if (c_i == 8'h00) fin = 1'b1;
          else if (c_i == 8'h3B && (kw_i & K_INTER) == '0) phase_o = PH_PSTART;
          else rej = 1'b1;
        end
      end
      PH_RANGE_PRE, PH_RANGE_NUM, PH_RANGE_POST: begin
        rng_ok = !(acc_i < first_i || acc_i > first_i + 32'd1);
        if (phase_i != PH_RANGE_POST && is_dig) begin
          acc_o = acc10; phase_o = PH_RANGE_NUM;
        end else if (phase_i == PH_RANGE_PRE && sp) phase_o = PH_RANGE_PRE;
        else if (phase_i != PH_RANGE_POST && !rng_ok) rej = 1'b1;
        else if (sp) phase_o = PH_RANGE_POST;
        else if (c_i == 8'h00) fin = 1'b1;
        else if (c_i == 8'h3B) phase_o = PH_PSTART;
        else begin
          // Stray character restarts a parameter on this same byte.
          kw_o = K_ALL; pos_o = 4'd1; kp = '0;
          for (int unsigned i = 0; i < NumKw; i++) begin
            if (lc == kw_char(i, 4'd0)) kp[i] = 1'b1;
          end
          if (kp == '0) begin phase_o = PH_SKIP; pos_o = '0; end
          else begin kw_o = kp; phase_o = PH_KEYWORD; end
        end
      end
      PH_CHAN2: begin
        if (is_dig) acc_o = acc10;
        else if (first_i + 32'd1 != acc_i) rej = 1'b1;
        else if (c_i == 8'h00) fin = 1'b1;
        else if (c_i == 8'h3B) phase_o = PH_PSTART;
        else rej = 1'b1;
      end
      PH_ADDR_PRE: begin
        if (!sp) begin
          if (c_i == 8'h00 || c_i == 8'h3B) rej = 1'b1;
          else begin
            cnt_o = CntW'(1); phase_o = PH_ADDR; emit_o = 1'b1;
            res_o.kind = ((kw_i & K_DEST) != '0) ? KIND_DEST : KIND_SRC;
            res_o.chr = c_i;
          end
        end
      end
      PH_ADDR: begin
        if (c_i == 8'h00) fin = 1'b1;
        else if (c_i == 8'h3B) phase_o = PH_PSTART;
        else if (cnt_i < CntMax) begin
          cnt_o = cnt_i + CntW'(1); emit_o = 1'b1;
          res_o.kind = ((kw_i & K_DEST) != '0) ? KIND_DEST : KIND_SRC;
          res_o.idx = 6'(cnt_i);
          res_o.chr = c_i;
        end
      end
      PH_FAIL: if (c_i == 8'h00) begin fin = 1'b1; fok = 1'b0; end
      default: rej = 1'b1;
    endcase
    if (rej) begin
      failed_o = 1'b1; phase_o = PH_FAIL;
      if (c_i == 8'h00) begin fin = 1'b1; fok = 1'b0; end
    end
    if (fin) begin
      emit_o = 1'b1;
      res_o = '0;
      res_o.ok = fok && !(failed_i || rej);
      res_o.uni = flags_o[0];
      res_o.multi = flags_o[1];
      res_o.ssrc_ok = flags_o[2];
      res_o.client = client_o;
      res_o.server = server_o;
      res_o.ssrc = ssrc_o;
      phase_o = PH_PROTO; kw_o = K_ALL; pos_o = '0; acc_o = '0; first_o = '0;
      cnt_o = '0; failed_o = 1'b0; flags_o = '0;
      client_o = '0; server_o = '0; ssrc_o = '0;
    end
  end

endmodule

/* hdl/rtsp_transport_header_parser.sv */
// Top level of the RTSP Transport header parser: registers, handshakes and
// output stage. Depends on rtsp_pkg and rtsp_step.
//
// One header byte is accepted per cycle and evaluated in a single pass of
// combinational logic between the parser state registers and a one-entry
// result register; a byte 0 ends the header and yields a summary, and address
// value characters yield one character result each, up to ADDRESS_BYTES - 1
// per value. Throughput is one item per clock while results are taken; a
// result is valid in the cycle after its byte is accepted. The sole limit on
// rate is the result register: a byte is accepted whenever that register is
// empty or is being drained in the same cycle, so in_ready drops only while an
// undelivered result is held. Configuration writes take effect on the next byte.
module rtsp_transport_header_parser #(
  parameter int unsigned ADDRESS_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  header_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [5:0]  char_index_o,
  output logic [7:0]  char_value_o,
  output logic        parse_ok_o,
  output logic        unicast_seen_o,
  output logic        multicast_seen_o,
  output logic [31:0] client_port_value_o,
  output logic [31:0] server_port_value_o,
  output logic        ssrc_seen_o,
  output logic [31:0] ssrc_value_o
);
  import rtsp_pkg::*;

  localparam int unsigned CntW = $clog2(ADDRESS_BYTES);

  logic [63:0] ptext_q;
  logic [3:0]  plen_q;
  logic        tcp_q;
  logic [7:0]  chan_q;

  phase_e      phase_q, phase_d;
  logic [8:0]  kw_q, kw_d;
  logic [3:0]  pos_q, pos_d;
  logic [31:0] acc_q, acc_d, first_q, first_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        failed_q, failed_d;
  logic [2:0]  flags_q, flags_d;
  logic [31:0] client_q, client_d, server_q, server_d, ssrc_q, ssrc_d;

  logic        emit;
  result_t     res_d, res_q;
  logic        ovalid_q;
  logic        accept;

  assign in_ready_o = !ovalid_q || out_ready_i;
  assign accept = in_valid_i && in_ready_o;

  rtsp_step #(.AddressBytes(ADDRESS_BYTES)) u_step (
    .c_i(header_byte_i), .protocol_text_i(ptext_q), .protocol_length_i(plen_q),
    .use_tcp_i(tcp_q), .interleave_channel_i(chan_q),
    .phase_i(phase_q), .kw_i(kw_q), .pos_i(pos_q), .acc_i(acc_q), .first_i(first_q),
    .cnt_i(cnt_q), .failed_i(failed_q), .flags_i(flags_q), .client_i(client_q),
    .server_i(server_q), .ssrc_i(ssrc_q),
    .phase_o(phase_d), .kw_o(kw_d), .pos_o(pos_d), .acc_o(acc_d), .first_o(first_d),
    .cnt_o(cnt_d), .failed_o(failed_d), .flags_o(flags_d), .client_o(client_d),
    .server_o(server_d), .ssrc_o(ssrc_d), .emit_o(emit), .res_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptext_q <= '0; plen_q <= '0; tcp_q <= 1'b0; chan_q <= '0;
      phase_q <= PH_PROTO; kw_q <= K_ALL; pos_q <= '0; acc_q <= '0; first_q <= '0;
      cnt_q <= '0; failed_q <= 1'b0; flags_q <= '0;
      client_q <= '0; server_q <= '0; ssrc_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PROTO_TEXT: ptext_q <= cfg_data_i;
          REG_PROTO_LEN:  plen_q <= cfg_data_i[3:0];
          REG_USE_TCP:    tcp_q <= cfg_data_i[0];
          REG_CHANNEL:    chan_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_q <= phase_d; kw_q <= kw_d; pos_q <= pos_d; acc_q <= acc_d;
        first_q <= first_d; cnt_q <= cnt_d; failed_q <= failed_d; flags_q <= flags_d;
        client_q <= client_d; server_q <= server_d; ssrc_q <= ssrc_d;
      end
      if (in_ready_o) ovalid_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) res_q <= res_d;
  end

  assign out_valid_o = ovalid_q;
  assign result_kind_o = res_q.kind;
  assign char_index_o = res_q.idx;
  assign char_value_o = res_q.chr;
  assign parse_ok_o = res_q.ok;
  assign unicast_seen_o = res_q.uni;
  assign multicast_seen_o = res_q.multi;
  assign client_port_value_o = res_q.client;
  assign server_port_value_o = res_q.server;
  assign ssrc_seen_o = res_q.ssrc_ok;
  assign ssrc_value_o = res_q.ssrc;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_ready_i |=> ovalid_q && $stable(res_q))
    else $error("result lost while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ovalid_q |-> in_ready_o) else $error("stall without pending result");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && header_byte_i == 8'h00 |=> phase_q == PH_PROTO && !failed_q)
    else $error("header state not cleared");
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && header_byte_i == 8'h00 |=> ovalid_q && res_q.kind == KIND_SUMMARY)
    else $error("missing summary");
`endif

endmodule
